// File: rtl/dts_pkg.sv
// Shared types and constants for the duration-to-seconds parser.
// Holds the phase encoding, character classes and time weights; no dependencies.
`default_nettype none

package dts_pkg;

    localparam int unsigned VALUE_W = 32;

    localparam logic [VALUE_W-1:0] SEC_PER_MIN  = 32'd60;
    localparam logic [VALUE_W-1:0] MIN_PER_HOUR = 32'd60;
    localparam logic [VALUE_W-1:0] HOUR_PER_DAY = 32'd24;
    localparam logic [VALUE_W-1:0] DAY_PER_WEEK = 32'd7;
    localparam logic [VALUE_W-1:0] SEC_PER_HOUR = 32'(SEC_PER_MIN * MIN_PER_HOUR);
    localparam logic [VALUE_W-1:0] SEC_PER_DAY  = 32'(SEC_PER_HOUR * HOUR_PER_DAY);
    localparam logic [VALUE_W-1:0] SEC_PER_WEEK = 32'(SEC_PER_DAY * DAY_PER_WEEK);
    localparam logic [VALUE_W-1:0] SEC_PER_SEC  = 32'd1;
    localparam logic [VALUE_W-1:0] DIGIT_BASE   = 32'd10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_W     = 8'h57;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_S     = 8'h53;

    typedef enum logic [4:0] {
        PH_SIGN = 5'b00001,
        PH_P    = 5'b00010,
        PH_DATE = 5'b00100,
        PH_TIME = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    typedef enum logic [3:0] {
        CC_OTHER,
        CC_PLUS,
        CC_MINUS,
        CC_P,
        CC_W,
        CC_D,
        CC_T,
        CC_H,
        CC_M,
        CC_S,
        CC_DIGIT
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
    } char_info_t;

endpackage

`default_nettype wire

// File: rtl/duration_to_seconds_parser.sv
// Usage notes for duration_to_seconds_parser.
// The input channel (s_valid/s_ready) carries one word per character of a
// duration string such as "-P1DT2H30M5S" (s_kind = 0), followed by an end
// word (s_kind = 1) whose s_character is ignored. Character words produce no
// result; each end word produces one result word on the output channel
// (m_valid/m_ready) with m_ok and the signed total m_seconds (0 when not ok).
// Words enter an input register and are parsed by one short step of logic
// into the parser state, so one word is taken every cycle unless an end
// word waits for the busy output register, which holds each result.
// A stalled receiver blocks only end words: character words keep flowing
// while a result waits, and s_ready drops only when an end word needs the
// occupied output register. The constant multiply by the designator weight
// plus the running add sets the cycle time.
// After an end word the parser returns to its starting state, ready for the
// next string. aresetn (synchronous, active low) empties both registers and
// clears the parser state.
// Depends on dts_pkg and dts_char_decode.
`default_nettype none

module duration_to_seconds_parser
    import dts_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_kind,
    input  wire logic [7:0]         s_character,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_ok,
    output logic signed [VALUE_W-1:0] m_seconds
);

    logic               in_valid_reg, in_valid_next;
    logic               in_kind_reg;
    logic [7:0]         in_char_reg;

    phase_t             phase_reg, phase_next;
    logic               negative_reg, negative_next;
    logic               failed_reg, failed_next;
    logic [VALUE_W-1:0] number_reg, number_next;
    logic [VALUE_W-1:0] total_reg, total_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_ok_reg, m_ok_next;
    logic [VALUE_W-1:0] m_seconds_reg, m_seconds_next;

    char_info_t         info;
    logic               out_free;
    logic               advance;
    logic               step;
    logic               end_step;
    logic [VALUE_W-1:0] weight;
    logic [VALUE_W-1:0] product;
    logic [VALUE_W-1:0] accum;
    logic [VALUE_W-1:0] number_digit;

    dts_char_decode u_decode (
        .character (in_char_reg),
        .info      (info)
    );

    // Only an end word needs the output register; characters always advance.
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = !in_kind_reg || out_free;
    assign step     = in_valid_reg && advance;
    assign end_step = step && in_kind_reg;
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        unique case (info.cls)
            CC_W:    weight = SEC_PER_WEEK;
            CC_D:    weight = SEC_PER_DAY;
            CC_H:    weight = SEC_PER_HOUR;
            CC_M:    weight = SEC_PER_MIN;
            default: weight = SEC_PER_SEC;
        endcase
    end

    assign product      = VALUE_W'(number_reg * weight);
    assign accum        = total_reg + product;
    assign number_digit = VALUE_W'(number_reg * DIGIT_BASE) + {28'd0, info.digit};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        failed_next   = failed_reg;
        number_next   = number_reg;
        total_next    = total_reg;
        if (end_step) begin
            phase_next    = PH_SIGN;
            negative_next = 1'b0;
            failed_next   = 1'b0;
            number_next   = '0;
            total_next    = '0;
        end else if (step && !failed_reg) begin
            unique case (phase_reg)
                PH_SIGN: begin
                    priority case (info.cls)
                        CC_PLUS:  phase_next = PH_P;
                        CC_MINUS: begin
                            negative_next = 1'b1;
                            phase_next    = PH_P;
                        end
                        CC_P:     phase_next = PH_DATE;
                        default:  failed_next = 1'b1;
                    endcase
                end
                PH_P: begin
                    if (info.cls == CC_P) begin
                        phase_next = PH_DATE;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_DATE: begin
                    priority case (info.cls)
                        CC_W: begin
                            total_next = accum;
                            phase_next = PH_DONE;
                        end
                        CC_D: begin
                            total_next  = accum;
                            number_next = '0;
                        end
                        CC_T:     phase_next  = PH_TIME;
                        CC_DIGIT: number_next = number_digit;
                        default:  failed_next = 1'b1;
                    endcase
                end
                PH_TIME: begin
                    priority case (info.cls)
                        CC_H, CC_M: begin
                            total_next  = accum;
                            number_next = '0;
                        end
                        CC_S: begin
                            total_next = accum;
                            phase_next = PH_DONE;
                        end
                        CC_DIGIT: number_next = number_digit;
                        default:  failed_next = 1'b1;
                    endcase
                end
                default: failed_next = 1'b1;
            endcase
        end
    end

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_ok_next      = m_ok_reg;
        m_seconds_next = m_seconds_reg;
        if (end_step) begin
            m_valid_next = 1'b1;
            m_ok_next    = !failed_reg;
            if (failed_reg) begin
                m_seconds_next = '0;
            end else if (negative_reg) begin
                m_seconds_next = '0 - total_reg;
            end else begin
                m_seconds_next = total_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_SIGN;
            negative_reg <= 1'b0;
            failed_reg   <= 1'b0;
            number_reg   <= '0;
            total_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            failed_reg   <= failed_next;
            number_reg   <= number_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_char_reg <= s_character;
        end
        m_ok_reg      <= m_ok_next;
        m_seconds_reg <= m_seconds_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_ok      = m_ok_reg;
    assign m_seconds = $signed(m_seconds_reg);

`ifndef NO_ASSERTIONS
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("parser phase is not one-hot");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ok_reg |-> m_seconds_reg == '0)
        else $error("failed result carries a nonzero total");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        end_step |=> phase_reg == PH_SIGN && !failed_reg && !negative_reg
                     && number_reg == '0 && total_reg == '0)
        else $error("parser state not cleared after end word");

    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg && !end_step |=> failed_reg)
        else $error("error flag dropped before end word");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        end_step |-> !m_valid_reg || m_ready)
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/dts_char_decode.sv
// Character classifier for the duration-to-seconds parser.
// Maps an ASCII code to a designator class and a digit value; uses dts_pkg.
`default_nettype none

module dts_char_decode
    import dts_pkg::*;
(
    input  wire logic [7:0] character,
    output char_info_t      info
);

    logic       is_digit;
    logic [7:0] digit_full;

    assign is_digit   = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign digit_full = character - CHAR_ZERO;

    always_comb begin
        info.digit = digit_full[3:0];
        unique case (character)
            CHAR_PLUS:  info.cls = CC_PLUS;
            CHAR_MINUS: info.cls = CC_MINUS;
            CHAR_P:     info.cls = CC_P;
            CHAR_W:     info.cls = CC_W;
            CHAR_D:     info.cls = CC_D;
            CHAR_T:     info.cls = CC_T;
            CHAR_H:     info.cls = CC_H;
            CHAR_M:     info.cls = CC_M;
            CHAR_S:     info.cls = CC_S;
            default:    info.cls = is_digit ? CC_DIGIT : CC_OTHER;
        endcase
    end

endmodule

`default_nettype wire
